/* src/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BGSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define BGSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/bgsr_pkg.sv */
package bgsr_pkg;

  // Fixed field widths of the stream and register items.
  localparam int GW_FIELD_W = 5;
  localparam int MARGIN_W   = 4;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int WMUL_W   = 5;
  localparam int WGAP_W   = 4;
  localparam int HMUL_W   = 3;
  localparam int HGAP_W   = 4;
  localparam int ROWS_W   = 6;
  localparam int SPACE_W  = 4;
  localparam int ROWCNT_W = 5;

  // Limits on the effective register values.
  localparam int WMUL_MAX = 16;
  localparam int HMUL_MAX = 4;
  localparam int ROWS_MAX = 32;

  // At most this many spans leave for one glyph row.
  localparam int MAX_SPANS  = 64;
  localparam int SPAN_CNT_W = 7;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WMUL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WGAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HMUL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HGAP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SKIP,
    ST_SCAN,
    ST_FLUSH,
    ST_FINISH
  } bgsr_state_e;

  // Controls of the row bit shifter.
  typedef struct packed {
    logic load;
    logic shift;
    logic mark;
    logic rewind;
  } bgsr_shift_ctrl_t;

  // Controls of the coordinate unit.
  typedef struct packed {
    logic reload;
    logic setup;
    logic step;
    logic next_rep;
    logic finish;
  } bgsr_coord_ctrl_t;

endpackage

/* src/bgsr_bit_shifter.sv */
module bgsr_bit_shifter
  import bgsr_pkg::*;
#(
  parameter int ROW_BITS = 32
) (
  input  logic                  clk_i,
  input  bgsr_shift_ctrl_t      ctrl_i,
  input  logic [ROW_BITS-1:0]   row_i,
  output logic                  bit_o
);

  logic [ROW_BITS-1:0] work_q;
  logic [ROW_BITS-1:0] base_q;

  // The working copy moves one bit per cycle toward the top while shift is set; zeros fill in,
  // so bits past the end of the row read as unlit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      work_q <= row_i;
    end else if (ctrl_i.shift) begin
      work_q <= {work_q[ROW_BITS-2:0], 1'b0};
    end else if (ctrl_i.rewind) begin
      work_q <= base_q;
    end
    if (ctrl_i.mark) begin
      base_q <= work_q;
    end
  end

  assign bit_o = work_q[ROW_BITS-1];

endmodule

/* src/bgsr_coord_unit.sv */
module bgsr_coord_unit
  import bgsr_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int GW_W       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bgsr_coord_ctrl_t              ctrl_i,
  input  logic signed [COORD_BITS-1:0]  text_x_i,
  input  logic signed [COORD_BITS-1:0]  text_y_i,
  input  logic [GW_W-1:0]               width_i,
  input  logic [WMUL_W-1:0]             wmul_i,
  input  logic [WGAP_W-1:0]             wgap_i,
  input  logic [HMUL_W-1:0]             hmul_i,
  input  logic [HGAP_W-1:0]             hgap_i,
  input  logic [ROWS_W-1:0]             rows_i,
  input  logic [SPACE_W-1:0]            space_i,
  output logic signed [COORD_BITS-1:0]  span_xs_o,
  output logic signed [COORD_BITS-1:0]  span_xe_o,
  output logic signed [COORD_BITS-1:0]  span_y_o
);

  localparam int WW     = COORD_BITS + 12;
  localparam int ADV_W  = GW_W + 6;
  localparam int YSTP_W = ROWCNT_W + 5;
  localparam int SPM_W  = SPACE_W + WMUL_W;
  localparam logic signed [WW-1:0] C_MAX = WW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [WW-1:0] C_MIN = -C_MAX - WW'(1);

  logic signed [COORD_BITS-1:0] pen_q, pen_d;
  logic signed [COORD_BITS-1:0] top_q, top_d;
  logic [ROWCNT_W-1:0]          rowc_q, rowc_d;
  logic signed [WW-1:0]         x_q, x_d;
  logic signed [WW-1:0]         y_q, y_d;
  logic [ADV_W-1:0]             adv_q, adv_d;

  logic [5:0]          xdelta;
  logic [4:0]          hstep;
  logic [YSTP_W-1:0]   ystep;
  logic [ADV_W-1:0]    adv_mul;
  logic [SPM_W-1:0]    space_mul;
  logic signed [WW-1:0] pen_adv;
  logic signed [WW-1:0] xe_wide;
  logic                 row_end;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [WW-1:0] v);
    if (v > C_MAX) begin
      return COORD_BITS'(C_MAX);
    end else if (v < C_MIN) begin
      return COORD_BITS'(C_MIN);
    end
    return COORD_BITS'(v);
  endfunction

  // Small products: pixel pitch, row pitch and the pen advance.
  assign xdelta    = {1'b0, wmul_i} + {2'b00, wgap_i};
  assign hstep     = {2'b00, hmul_i} + {1'b0, hgap_i};
  assign ystep     = YSTP_W'(rowc_q) * YSTP_W'(hstep);
  assign adv_mul   = ADV_W'(width_i) * ADV_W'(xdelta);
  assign space_mul = SPM_W'(space_i) * SPM_W'(wmul_i);
  assign pen_adv   = WW'(pen_q) + WW'(adv_q) + WW'(space_mul);
  assign row_end   = (({1'b0, rowc_q} + 6'd1) >= rows_i);
  assign xe_wide   = x_q + WW'(wmul_i) - WW'(1);

  // Next values of the pen, the line origin and the scan position.
  always_comb begin
    pen_d  = pen_q;
    top_d  = top_q;
    rowc_d = rowc_q;
    x_d    = x_q;
    y_d    = y_q;
    adv_d  = adv_q;
    if (ctrl_i.reload) begin
      pen_d  = text_x_i;
      top_d  = text_y_i;
      rowc_d = '0;
    end
    if (ctrl_i.setup) begin
      x_d   = WW'(pen_q);
      y_d   = WW'(top_q) + WW'(ystep);
      adv_d = adv_mul;
    end
    if (ctrl_i.step) begin
      x_d = x_q + WW'(xdelta);
    end
    if (ctrl_i.next_rep) begin
      x_d = WW'(pen_q);
      y_d = y_q + WW'(1);
    end
    if (ctrl_i.finish) begin
      if (row_end) begin
        pen_d  = sat_coord(pen_adv);
        rowc_d = '0;
      end else begin
        rowc_d = rowc_q + ROWCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q  <= '0;
      top_q  <= '0;
      rowc_q <= '0;
    end else begin
      pen_q  <= pen_d;
      top_q  <= top_d;
      rowc_q <= rowc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    adv_q <= adv_d;
  end

  assign span_xs_o = sat_coord(x_q);
  assign span_xe_o = sat_coord(xe_wide);
  assign span_y_o  = sat_coord(y_q);

endmodule

/* src/bitmap_glyph_span_raster_unit.sv */
// Bitmap glyph span rasterizer.
// The slave stream takes one glyph row per item: the row bitmap (leftmost
// font pixel in the top bit), glyph width, left margin and text origin in
// tdata, and the new-text flag in tuser. The master stream returns one
// horizontal span per lit font pixel and row repeat, with tlast on the final
// span of each row. A dark row gives no item at all.
// Registers are written on the cfg channel, which is always ready; write them
// only while no row is in flight.
// While a row is in the block, the row shift register walks the left margin
// and then every font pixel of every repeat, one bit per cycle while no span
// has to wait on a stalled output register. Each span waits in a pending
// stage until the next lit pixel or the end of the row; a new row is taken
// once the last span of the previous one sits in the output register. When
// the receiver stalls, the output register and one pending span hold and
// the bit scan waits. Reset clears the pen, line origin and row counter to
// zero and loads the register defaults.
`include "assert_macros.svh"

module bitmap_glyph_span_raster_unit
  import bgsr_pkg::*;
#(
  parameter int ROW_BITS        = 32,
  parameter int MAX_GLYPH_WIDTH = 16,
  parameter int COORD_BITS      = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Glyph rows in.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // row_bitmap, glyph_width, left_margin, text_x, text_y, zero fill
  input  logic [((ROW_BITS+GW_FIELD_W+MARGIN_W+2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // new_text
  input  logic                  s_axis_tuser,
  // Spans out.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // span_x_start, span_x_end, span_y, span_color, zero fill
  output logic [((3*COORD_BITS+COLOR_W+7)/8)*8-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int OFF_GW   = ROW_BITS;
  localparam int OFF_MG   = OFF_GW + GW_FIELD_W;
  localparam int OFF_TX   = OFF_MG + MARGIN_W;
  localparam int OFF_TY   = OFF_TX + COORD_BITS;
  localparam int OUT_BITS = 3 * COORD_BITS + COLOR_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int GW_W     = $clog2(MAX_GLYPH_WIDTH + 1);

  // Registers.
  logic [WMUL_W-1:0]  wmul_q;
  logic [WGAP_W-1:0]  wgap_q;
  logic [HMUL_W-1:0]  hmul_q;
  logic [HGAP_W-1:0]  hgap_q;
  logic [ROWS_W-1:0]  rows_q;
  logic [SPACE_W-1:0] space_q;
  logic [COLOR_W-1:0] color_q;

  bgsr_state_e state_q, state_d;

  logic [GW_W-1:0]       width_q, width_d;
  logic [MARGIN_W-1:0]   skip_q;
  logic [GW_W-1:0]       pix_q;
  logic [HMUL_W-1:0]     rep_q;
  logic [SPAN_CNT_W-1:0] span_cnt_q;

  logic                         pend_v_q;
  logic signed [COORD_BITS-1:0] pend_xs_q, pend_xe_q, pend_y_q;
  logic                         m_valid_q;
  logic [OUT_W-1:0]             m_data_q;
  logic                         m_last_q;

  logic s_acc, cfg_acc, out_free, can_emit, rep_done, last_rep, capped, bit_lit;
  logic push, push_last, pend_load, skip_dec, pix_step, rep_next;
  bgsr_shift_ctrl_t sh_ctrl;
  bgsr_coord_ctrl_t co_ctrl;
  logic signed [COORD_BITS-1:0] span_xs, span_xe, span_y;

  logic [GW_FIELD_W-1:0] gw_in;
  logic [WMUL_W-1:0]     cfg_wmul;
  logic [HMUL_W-1:0]     cfg_hmul;
  logic [ROWS_W-1:0]     cfg_rows;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !m_valid_q || m_axis_tready;
  assign can_emit = !pend_v_q || out_free;
  assign rep_done = (pix_q == width_q);
  assign last_rep = (rep_q == hmul_q - HMUL_W'(1));
  assign capped   = (span_cnt_q == SPAN_CNT_W'(MAX_SPANS));

  assign gw_in   = s_axis_tdata[OFF_MG-1:OFF_GW];
  assign width_d = (32'(gw_in) > MAX_GLYPH_WIDTH) ? GW_W'(MAX_GLYPH_WIDTH) : GW_W'(gw_in);

  // Out-of-range register values are clamped as they are written.
  assign cfg_wmul = (cfg_data_i[WMUL_W-1:0] == '0) ? WMUL_W'(1) :
                    (32'(cfg_data_i[WMUL_W-1:0]) > WMUL_MAX) ? WMUL_W'(WMUL_MAX) :
                    cfg_data_i[WMUL_W-1:0];
  assign cfg_hmul = (cfg_data_i[HMUL_W-1:0] == '0) ? HMUL_W'(1) :
                    (32'(cfg_data_i[HMUL_W-1:0]) > HMUL_MAX) ? HMUL_W'(HMUL_MAX) :
                    cfg_data_i[HMUL_W-1:0];
  assign cfg_rows = (cfg_data_i[ROWS_W-1:0] == '0) ? ROWS_W'(1) :
                    (32'(cfg_data_i[ROWS_W-1:0]) > ROWS_MAX) ? ROWS_W'(ROWS_MAX) :
                    cfg_data_i[ROWS_W-1:0];

  bgsr_bit_shifter #(
    .ROW_BITS (ROW_BITS)
  ) u_shifter (
    .clk_i  (clk_i),
    .ctrl_i (sh_ctrl),
    .row_i  (s_axis_tdata[ROW_BITS-1:0]),
    .bit_o  (bit_lit)
  );

  bgsr_coord_unit #(
    .COORD_BITS (COORD_BITS),
    .GW_W       (GW_W)
  ) u_coord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (co_ctrl),
    .text_x_i  (s_axis_tdata[OFF_TY-1:OFF_TX]),
    .text_y_i  (s_axis_tdata[OFF_TY+COORD_BITS-1:OFF_TY]),
    .width_i   (width_q),
    .wmul_i    (wmul_q),
    .wgap_i    (wgap_q),
    .hmul_i    (hmul_q),
    .hgap_i    (hgap_q),
    .rows_i    (rows_q),
    .space_i   (space_q),
    .span_xs_o (span_xs),
    .span_xe_o (span_xe),
    .span_y_o  (span_y)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_acc) state_d = ST_SETUP;
      end
      ST_SETUP: state_d = ST_SKIP;
      ST_SKIP: begin
        if (skip_q == '0) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (capped || (rep_done && last_rep)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (!pend_v_q || out_free) state_d = ST_FINISH;
      end
      ST_FINISH: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Strobes for the shifter, coordinate unit, counters and span stages.
  always_comb begin
    sh_ctrl   = '0;
    co_ctrl   = '0;
    push      = 1'b0;
    push_last = 1'b0;
    pend_load = 1'b0;
    skip_dec  = 1'b0;
    pix_step  = 1'b0;
    rep_next  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        sh_ctrl.load   = s_acc;
        co_ctrl.reload = s_acc && s_axis_tuser;
      end
      ST_SETUP: co_ctrl.setup = 1'b1;
      ST_SKIP: begin
        if (skip_q != '0) begin
          sh_ctrl.shift = 1'b1;
          skip_dec      = 1'b1;
        end else begin
          sh_ctrl.mark = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!capped) begin
          if (rep_done) begin
            if (!last_rep) begin
              sh_ctrl.rewind   = 1'b1;
              co_ctrl.next_rep = 1'b1;
              rep_next         = 1'b1;
            end
          end else if (!bit_lit || can_emit) begin
            sh_ctrl.shift = 1'b1;
            co_ctrl.step  = 1'b1;
            pix_step      = 1'b1;
            pend_load     = bit_lit;
            push          = bit_lit && pend_v_q;
          end
        end
      end
      ST_FLUSH: begin
        push      = pend_v_q && out_free;
        push_last = 1'b1;
      end
      ST_FINISH: co_ctrl.finish = 1'b1;
      default: ;
    endcase
  end

  // Control state, counters and registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      width_q    <= '0;
      skip_q     <= '0;
      pix_q      <= '0;
      rep_q      <= '0;
      span_cnt_q <= '0;
      pend_v_q   <= 1'b0;
      m_valid_q  <= 1'b0;
      wmul_q     <= WMUL_W'(1);
      wgap_q     <= '0;
      hmul_q     <= HMUL_W'(1);
      hgap_q     <= '0;
      rows_q     <= ROWS_W'(8);
      space_q    <= SPACE_W'(1);
      color_q    <= '0;
    end else begin
      state_q <= state_d;
      if (s_acc) begin
        width_q    <= width_d;
        skip_q     <= s_axis_tdata[OFF_TX-1:OFF_MG];
        pix_q      <= '0;
        rep_q      <= '0;
        span_cnt_q <= '0;
      end
      if (skip_dec) skip_q <= skip_q - MARGIN_W'(1);
      if (pix_step) pix_q <= pix_q + GW_W'(1);
      if (rep_next) begin
        pix_q <= '0;
        rep_q <= rep_q + HMUL_W'(1);
      end
      if (pend_load) begin
        span_cnt_q <= span_cnt_q + SPAN_CNT_W'(1);
        pend_v_q   <= 1'b1;
      end else if (push) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_acc) begin
        case (cfg_index_i)
          REG_WMUL:  wmul_q  <= cfg_wmul;
          REG_WGAP:  wgap_q  <= cfg_data_i[WGAP_W-1:0];
          REG_HMUL:  hmul_q  <= cfg_hmul;
          REG_HGAP:  hgap_q  <= cfg_data_i[HGAP_W-1:0];
          REG_ROWS:  rows_q  <= cfg_rows;
          REG_SPACE: space_q <= cfg_data_i[SPACE_W-1:0];
          REG_COLOR: color_q <= cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pending span and output register payloads.
  always_ff @(posedge clk_i) begin
    if (pend_load) begin
      pend_xs_q <= span_xs;
      pend_xe_q <= span_xe;
      pend_y_q  <= span_y;
    end
    if (push) begin
      m_data_q <= OUT_W'({color_q, pend_y_q, pend_xe_q, pend_xs_q});
      m_last_q <= push_last;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  `BGSR_ASSERT_IMP(a_pend_not_lost, pend_load && pend_v_q, push, "pending span overwritten")
  `BGSR_ASSERT_IMP(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "span left pending at idle")
  `BGSR_ASSERT_IMP(a_span_cap, pend_load, span_cnt_q < SPAN_CNT_W'(MAX_SPANS), "span cap passed")

endmodule
